@@ rtl/track_tile_geometric_match_unit_macros.svh @@
// Assertion helpers used by the top-level RTL module.
`ifndef TRACK_TILE_GEOMETRIC_MATCH_UNIT_MACROS_SVH
`define TRACK_TILE_GEOMETRIC_MATCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TTGM_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TTGM_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ttgm_pkg.sv @@
package ttgm_pkg;

  localparam int FRAC_BITS   = 4;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int EDGE        = 1320 * ONE;
  localparam int HOLE        = 103 * ONE;
  localparam longint HOLE_SQ = longint'(HOLE) * longint'(HOLE);
  localparam int HALF_BIG    = 110 * ONE;
  localparam int HALF_SMALL  = (2 * 220 * ONE + 3) / 6;
  localparam int SMALL_ID    = 144;
  localparam int UNKNOWN_MOM = 10000;
  localparam int NUM_K       = 530000 * ONE;
  localparam int SF_RESET    = 64;

  localparam int SMAX20 = 524287;
  localparam int UMAX20 = 1048575;

  // divider: num = scale * NUM_K, den = 16 * momentum
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 23;
  localparam int DIV_LAT = NUM_W;

  // square root of a sum of two squared 22-bit magnitudes
  localparam int MAG_W     = 22;
  localparam int SQRT_OUT_W = 23;
  localparam int SQRT_IN_W  = 2 * SQRT_OUT_W;
  localparam int SQRT_LAT   = SQRT_OUT_W;

  localparam int HALF_W = 16;

  // per-item flags carried alongside the long arithmetic
  typedef struct packed {
    logic                     acc;
    logic                     ed_hyp;
    logic signed [MAG_W-1:0]  ed_lin;
    logic                     td_zero;
    logic                     td_lin;
    logic [MAG_W-1:0]         td_lin_val;
  } side_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

@@ rtl/track_tile_geometric_match_unit.sv @@
// Track to tile geometric match.
// Input channel (in_valid / in_stall) carries one track/tile pair per transfer:
// impact point, momentum, tile id and tile centre. Output channel
// (out_valid / out_stall) returns one result per pair: acceptance flag, edge
// distance, search radius, tile distance, centre distance and match flag.
// The user must write scale_factor with scale_factor_we only while no
// item is in flight; the block does not enforce this. The radius divider
// retires one quotient bit per stage; the three square-root units run
// alongside in 23 stages. One pair is accepted per cycle unless stalled.
// When out_stall holds a waiting result, every stage holds and in_stall
// rises in the same cycle; bubbles are carried, nothing is dropped.
// Reset (rst, synchronous) empties the pipeline and sets scale_factor to 64.
`include "track_tile_geometric_match_unit_macros.svh"

module track_tile_geometric_match_unit
  import ttgm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               scale_factor_we,
  input  logic [7:0]         scale_factor,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] track_x,
  input  logic signed [19:0] track_y,
  input  logic signed [19:0] track_momentum,
  input  logic [7:0]         tile_id,
  input  logic signed [19:0] tile_x,
  input  logic signed [19:0] tile_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               in_acceptance,
  output logic signed [19:0] edge_distance,
  output logic [19:0]        search_radius,
  output logic [19:0]        tile_distance,
  output logic [19:0]        centre_distance,
  output logic               matched
);

  localparam int NST    = DIV_LAT + 2;
  localparam int FL_DLY = 1 + DIV_LAT - 4;
  localparam int SQ_DLY = 1 + DIV_LAT - 4 - SQRT_LAT;

  logic       adv;
  logic [7:0] sf;
  logic [NST-1:0] vld;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sf <= 8'(SF_RESET);
    end else if (scale_factor_we) begin
      sf <= scale_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 1: magnitudes, differences, half-size and momentum select, numerator, denominator
  logic signed [MAG_W-1:0] tx, ty, mx, my;
  logic [18:0]             mom;
  logic [19:0]             s1_ax, s1_ay;
  logic signed [MAG_W-1:0] s1_dxm, s1_dym;
  logic [HALF_W-1:0]       s1_half;
  logic [NUM_W-1:0]        s1_num;
  logic [DEN_W-1:0]        s1_den;

  assign tx  = MAG_W'(track_x);
  assign ty  = MAG_W'(track_y);
  assign mx  = MAG_W'(tile_x);
  assign my  = MAG_W'(tile_y);
  assign mom = (track_momentum > 0) ? track_momentum[18:0] : 19'(UNKNOWN_MOM);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax   <= 20'(mag(tx));
      s1_ay   <= 20'(mag(ty));
      s1_dxm  <= tx - mx;
      s1_dym  <= ty - my;
      s1_half <= (tile_id >= 8'(SMALL_ID)) ? HALF_W'(HALF_SMALL) : HALF_W'(HALF_BIG);
      s1_num  <= NUM_W'({24'd0, sf} * NUM_W'(NUM_K));
      s1_den  <= {mom, 4'b0000};
    end
  end

  // stage 2: tile edges, region flags, magnitudes
  logic signed [MAG_W-1:0] dx1, dx2, dy1, dy2, ex_s, ey_s;
  logic inx, iny, xhi, xlo, yhi, ylo;
  logic [MAG_W-1:0] adx1, adx2, ady1, ady2;

  assign dx1  = s1_dxm + $signed({6'b0, s1_half});
  assign dx2  = s1_dxm - $signed({6'b0, s1_half});
  assign dy1  = s1_dym + $signed({6'b0, s1_half});
  assign dy2  = s1_dym - $signed({6'b0, s1_half});
  assign inx  = (dx1 > 0) && (dx2 < 0);
  assign iny  = (dy1 > 0) && (dy2 < 0);
  assign xhi  = dx2 > 0;
  assign xlo  = dx1 < 0;
  assign yhi  = dy2 > 0;
  assign ylo  = dy1 < 0;
  assign adx1 = mag(dx1);
  assign adx2 = mag(dx2);
  assign ady1 = mag(dy1);
  assign ady2 = mag(dy2);
  assign ex_s = $signed({2'b00, s1_ax}) - MAG_W'(EDGE);
  assign ey_s = $signed({2'b00, s1_ay}) - MAG_W'(EDGE);

  logic [19:0]             s2_ax, s2_ay;
  logic [MAG_W-1:0]        s2_ex, s2_ey, s2_mx, s2_my, s2_cx, s2_cy, s2_tdlin;
  logic signed [MAG_W-1:0] s2_edx, s2_edy;
  logic s2_axlt, s2_aylt, s2_axgt, s2_aygt, s2_tdzero, s2_tdl;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ax     <= s1_ax;
      s2_ay     <= s1_ay;
      s2_ex     <= mag(ex_s);
      s2_ey     <= mag(ey_s);
      s2_edx    <= -ex_s;
      s2_edy    <= -ey_s;
      s2_axlt   <= s1_ax < 20'(EDGE);
      s2_aylt   <= s1_ay < 20'(EDGE);
      s2_axgt   <= s1_ax > 20'(EDGE);
      s2_aygt   <= s1_ay > 20'(EDGE);
      s2_mx     <= mag(s1_dxm);
      s2_my     <= mag(s1_dym);
      s2_cx     <= xhi ? adx2 : adx1;
      s2_cy     <= yhi ? ady2 : ady1;
      // a point on an edge line outside the span counts as touching
      s2_tdzero <= (inx && iny) ||
                   (!inx && !iny && !((xhi || xlo) && (yhi || ylo)));
      s2_tdl    <= iny || inx;
      s2_tdlin  <= iny ? ((adx1 < adx2) ? adx1 : adx2)
                       : ((ady1 < ady2) ? ady1 : ady2);
    end
  end

  // stage 3: squares
  logic [39:0] s3_ax2, s3_ay2;
  logic [2*MAG_W-1:0] s3_ex2, s3_ey2, s3_mx2, s3_my2, s3_cx2, s3_cy2;
  logic s3_axlt, s3_aylt, s3_axgt, s3_aygt, s3_tdzero, s3_tdl;
  logic signed [MAG_W-1:0] s3_edx, s3_edy;
  logic [MAG_W-1:0] s3_tdlin;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ax2    <= s2_ax * s2_ax;
      s3_ay2    <= s2_ay * s2_ay;
      s3_ex2    <= s2_ex * s2_ex;
      s3_ey2    <= s2_ey * s2_ey;
      s3_mx2    <= s2_mx * s2_mx;
      s3_my2    <= s2_my * s2_my;
      s3_cx2    <= s2_cx * s2_cx;
      s3_cy2    <= s2_cy * s2_cy;
      s3_axlt   <= s2_axlt;
      s3_aylt   <= s2_aylt;
      s3_axgt   <= s2_axgt;
      s3_aygt   <= s2_aygt;
      s3_edx    <= s2_edx;
      s3_edy    <= s2_edy;
      s3_tdzero <= s2_tdzero;
      s3_tdl    <= s2_tdl;
      s3_tdlin  <= s2_tdlin;
    end
  end

  // stage 4: sums, acceptance, edge selection
  logic [40:0] r2;
  logic        inner, acc;
  side_t       side_next, s4_side;
  logic [SQRT_IN_W-1:0] s4_esum, s4_msum, s4_csum;

  assign r2    = {1'b0, s3_ax2} + {1'b0, s3_ay2};
  assign inner = r2 > 41'(HOLE_SQ);
  assign acc   = inner && s3_axlt && s3_aylt;

  always_comb begin
    side_next            = '0;
    side_next.acc        = acc;
    side_next.td_zero    = s3_tdzero;
    side_next.td_lin     = s3_tdl;
    side_next.td_lin_val = s3_tdlin;
    side_next.ed_hyp     = 1'b0;
    if (acc) begin
      side_next.ed_lin = (s3_edx < s3_edy) ? s3_edx : s3_edy;
    end else if (s3_axgt && s3_aylt) begin
      side_next.ed_lin = s3_edx;
    end else if (s3_aygt && s3_axlt) begin
      side_next.ed_lin = s3_edy;
    end else begin
      side_next.ed_hyp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side <= side_next;
      s4_esum <= SQRT_IN_W'({1'b0, s3_ex2} + {1'b0, s3_ey2});
      s4_msum <= SQRT_IN_W'({1'b0, s3_mx2} + {1'b0, s3_my2});
      s4_csum <= SQRT_IN_W'({1'b0, s3_cx2} + {1'b0, s3_cy2});
    end
  end

  // long units
  logic [NUM_W-1:0]      quo;
  logic [SQRT_OUT_W-1:0] e_root, m_root, c_root;

  ttgm_div u_div (.clk(clk), .en(adv), .num(s1_num), .den(s1_den), .quo(quo));
  ttgm_isqrt u_sqrt_e (.clk(clk), .en(adv), .rad(s4_esum), .root(e_root));
  ttgm_isqrt u_sqrt_m (.clk(clk), .en(adv), .rad(s4_msum), .root(m_root));
  ttgm_isqrt u_sqrt_c (.clk(clk), .en(adv), .rad(s4_csum), .root(c_root));

  // align flags and roots with the quotient
  side_t                 side_d [FL_DLY];
  logic [SQRT_OUT_W-1:0] e_d [SQ_DLY];
  logic [SQRT_OUT_W-1:0] m_d [SQ_DLY];
  logic [SQRT_OUT_W-1:0] c_d [SQ_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= s4_side;
      for (int i = 1; i < FL_DLY; i++) side_d[i] <= side_d[i-1];
      e_d[0] <= e_root;
      m_d[0] <= m_root;
      c_d[0] <= c_root;
      for (int i = 1; i < SQ_DLY; i++) begin
        e_d[i] <= e_d[i-1];
        m_d[i] <= m_d[i-1];
        c_d[i] <= c_d[i-1];
      end
    end
  end

  // output stage: select, saturate, compare
  side_t                 fs;
  logic [SQRT_OUT_W-1:0] fe, fm, fc, td;

  assign fs = side_d[FL_DLY-1];
  assign fe = e_d[SQ_DLY-1];
  assign fm = m_d[SQ_DLY-1];
  assign fc = c_d[SQ_DLY-1];
  assign td = fs.td_zero ? '0 :
              fs.td_lin  ? SQRT_OUT_W'(fs.td_lin_val) : fc;

  always_ff @(posedge clk) begin
    if (adv) begin
      in_acceptance   <= fs.acc;
      edge_distance   <= fs.ed_hyp ?
                         ((fe > SQRT_OUT_W'(SMAX20)) ? 20'(SMAX20) : fe[19:0]) :
                         fs.ed_lin[19:0];
      search_radius   <= (quo > NUM_W'(UMAX20)) ? 20'(UMAX20) : quo[19:0];
      tile_distance   <= (td > SQRT_OUT_W'(UMAX20)) ? 20'(UMAX20) : td[19:0];
      centre_distance <= (fm > SQRT_OUT_W'(UMAX20)) ? 20'(UMAX20) : fm[19:0];
      matched         <= NUM_W'(td) < quo;
    end
  end

  `TTGM_NEXT(a_enter, in_valid && !in_stall, vld[0], "accepted item not in first stage")
  `TTGM_CHECK(a_match_le, out_valid && matched, tile_distance <= search_radius, "match above radius")
  `TTGM_CHECK(a_acc_edge, out_valid && in_acceptance, !edge_distance[19] && edge_distance != 20'd0, "accepted point with non-positive edge distance")
  `TTGM_CHECK(a_tile_le_centre, out_valid, tile_distance <= centre_distance, "tile distance beyond centre distance")

endmodule

@@ rtl/ttgm_div.sv @@
module ttgm_div
  import ttgm_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_s [NUM_W+1];
  logic [NUM_W-1:0] num_s [NUM_W+1];
  logic [NUM_W-1:0] quo_s [NUM_W+1];
  logic [DEN_W-1:0] den_s [NUM_W+1];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign den_s[0] = den;

  // one quotient bit per stage, restoring
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_s[i], num_s[i][NUM_W-1]};
    assign ge    = trial >= {1'b0, den_s[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, den_s[i]}) : DEN_W'(trial);
        num_s[i+1] <= num_s[i] << 1;
        quo_s[i+1] <= {quo_s[i][NUM_W-2:0], ge};
        den_s[i+1] <= den_s[i];
      end
    end
  end

  assign quo = quo_s[NUM_W];

endmodule

@@ rtl/ttgm_isqrt.sv @@
module ttgm_isqrt
  import ttgm_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  rad,
  output logic [SQRT_OUT_W-1:0] root
);

  localparam int RW = SQRT_OUT_W + 2;

  logic [RW-1:0]         rem_s  [SQRT_OUT_W+1];
  logic [SQRT_IN_W-1:0]  rad_s  [SQRT_OUT_W+1];
  logic [SQRT_OUT_W-1:0] root_s [SQRT_OUT_W+1];

  assign rem_s[0]  = '0;
  assign rad_s[0]  = rad;
  assign root_s[0] = '0;

  // one root bit per stage: bring down two radicand bits, try 4*root+1
  for (genvar i = 0; i < SQRT_OUT_W; i++) begin : g_stage
    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;
    logic          ge;
    assign shifted = {rem_s[i][RW-3:0], rad_s[i][SQRT_IN_W-1 -: 2]};
    assign trial   = {root_s[i], 2'b01};
    assign ge      = shifted >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= ge ? shifted - trial : shifted;
        rad_s[i+1]  <= rad_s[i] << 2;
        root_s[i+1] <= {root_s[i][SQRT_OUT_W-2:0], ge};
      end
    end
  end

  assign root = root_s[SQRT_OUT_W];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ttgm_pkg::*;

  typedef struct packed {
    logic               acc;
    logic signed [19:0] edist;
    logic [19:0]        radius;
    logic [19:0]        tdist;
    logic [19:0]        cdist;
    logic               match;
  } match_result_t;

  typedef struct {
    logic signed [19:0] tx;
    logic signed [19:0] ty;
    logic signed [19:0] mom;
    logic [7:0]         id;
    logic signed [19:0] mx;
    logic signed [19:0] my;
  } pair_t;

  // floored integer square root, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint labs(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned dist2d(input longint a, input longint b);
    longint unsigned ua, ub;
    ua = labs(a);
    ub = labs(b);
    return root_floor(ua * ua + ub * ub);
  endfunction

  function automatic longint lmin(input longint a, input longint b);
    return a < b ? a : b;
  endfunction

  class match_scoreboard;
    logic [7:0]    scale;
    match_result_t pending[$];
    int            errors;
    int            checked;

    function void note_pair(input pair_t it);
      match_result_t r;
      longint xt, yt, p, xm, ym, ax, ay, ed, half, x1, x2, y1, y2;
      longint unsigned mom, rad, td, cd, r2;
      bit inx, iny, outer;
      xt = it.tx; yt = it.ty; p = it.mom; xm = it.mx; ym = it.my;
      mom = (p > 0) ? p : UNKNOWN_MOM;
      rad = (longint'(scale) * 530000 * ONE) / (16 * mom);
      ax = labs(xt);
      ay = labs(yt);
      r2 = ax * ax + ay * ay;
      outer = ax < EDGE && ay < EDGE;
      r.acc = (r2 > HOLE_SQ) && outer;
      if (r.acc) ed = lmin(EDGE - ax, EDGE - ay);
      else if (ax > EDGE && ay < EDGE) ed = EDGE - ax;
      else if (ay > EDGE && ax < EDGE) ed = EDGE - ay;
      else ed = dist2d(ax - EDGE, ay - EDGE);
      if (ed > SMAX20) ed = SMAX20;
      if (ed < -SMAX20 - 1) ed = -SMAX20 - 1;
      r.edist = ed[19:0];
      half = (it.id >= SMALL_ID) ? HALF_SMALL : HALF_BIG;
      x1 = xm - half; x2 = xm + half;
      y1 = ym - half; y2 = ym + half;
      inx = xt > x1 && xt < x2;
      iny = yt > y1 && yt < y2;
      td = 0;
      if (!(inx && iny)) begin
        if (iny) td = lmin(labs(xt - x1), labs(xt - x2));
        else if (inx) td = lmin(labs(yt - y1), labs(yt - y2));
        else if (xt > x2 && yt > y2) td = dist2d(xt - x2, yt - y2);
        else if (xt > x2 && yt < y1) td = dist2d(xt - x2, yt - y1);
        else if (xt < x1 && yt < y1) td = dist2d(xt - x1, yt - y1);
        else if (xt < x1 && yt > y2) td = dist2d(xt - x1, yt - y2);
      end
      cd = dist2d(xt - xm, yt - ym);
      r.radius = 20'(rad > UMAX20 ? UMAX20 : rad);
      r.tdist = 20'(td > UMAX20 ? UMAX20 : td);
      r.cdist = 20'(cd > UMAX20 ? UMAX20 : cd);
      r.match = td < rad;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(input match_result_t got);
      match_result_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer");
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp acc=%0d ed=%0d rad=%0d td=%0d cd=%0d m=%0d",
                   e.acc, e.edist, e.radius, e.tdist, e.cdist, e.match);
          $display("          got acc=%0d ed=%0d rad=%0d td=%0d cd=%0d m=%0d",
                   got.acc, got.edist, got.radius, got.tdist, got.cdist, got.match);
        end
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               scale_factor_we = 0;
  logic [7:0]         scale_factor = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [19:0] track_x = 0, track_y = 0, track_momentum = 0;
  logic [7:0]         tile_id = 0;
  logic signed [19:0] tile_x = 0, tile_y = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               in_acceptance, matched;
  logic signed [19:0] edge_distance;
  logic [19:0]        search_radius, tile_distance, centre_distance;

  match_scoreboard board = new();
  longint cycles = 0;
  int     sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  track_tile_geometric_match_unit DUT (
    .clk(clk), .rst(rst),
    .scale_factor_we(scale_factor_we), .scale_factor(scale_factor),
    .in_valid(in_valid), .in_stall(in_stall),
    .track_x(track_x), .track_y(track_y), .track_momentum(track_momentum),
    .tile_id(tile_id), .tile_x(tile_x), .tile_y(tile_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .in_acceptance(in_acceptance), .edge_distance(edge_distance),
    .search_radius(search_radius), .tile_distance(tile_distance),
    .centre_distance(centre_distance), .matched(matched)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: after each transfer, draw a random stall before the next one unless rx_quiet is set
  int stall_left = 0;
  bit rx_quiet = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      match_result_t g;
      g.acc = in_acceptance; g.edist = edge_distance; g.radius = search_radius;
      g.tdist = tile_distance; g.cdist = centre_distance; g.match = matched;
      board.check_result(g);
      stall_left = rx_quiet ? 0 : $urandom_range(0, 7);
    end
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 0;
    end
  end

  // hold valid across items unless an idle gap is drawn
  task automatic send_pair(input pair_t it, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    track_x <= it.tx; track_y <= it.ty; track_momentum <= it.mom;
    tile_id <= it.id; tile_x <= it.mx; tile_y <= it.my;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pair(it);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_scale(input logic [7:0] v);
    scale_factor_we <= 1;
    scale_factor <= v;
    board.scale = v;
    @(posedge clk);
    scale_factor_we <= 0;
  endtask

  function automatic logic signed [19:0] coord(input int mode);
    case (mode)
      0: return 20'($urandom);
      1: return 20'($signed(20'($urandom_range(0, 2 * EDGE + 4000))) - EDGE - 2000);
      default: return 20'($signed(20'($urandom_range(0, 8000))) - 4000);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t it;
    int mode, off;
    mode = $urandom_range(0, 9);
    it.tx = coord(mode < 2 ? 0 : (mode < 8 ? 1 : 2));
    it.ty = coord(mode < 2 ? 0 : (mode < 8 ? 1 : 2));
    it.mom = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 80000));
    it.id = 8'($urandom);
    if (mode < 3) begin
      it.mx = 20'($urandom);
      it.my = 20'($urandom);
    end else begin
      // tile close to the point so inside, edge and corner cases all happen
      off = (it.id >= SMALL_ID) ? HALF_SMALL : HALF_BIG;
      it.mx = 20'(it.tx + $signed(20'($urandom_range(0, 4 * off))) - 2 * off);
      it.my = 20'(it.ty + $signed(20'($urandom_range(0, 4 * off))) - 2 * off);
      if ($urandom_range(0, 7) == 0) it.mx = 20'(it.tx + (($urandom & 1) ? off : -off));
    end
    return it;
  endfunction

  function automatic pair_t mk(input int tx, ty, mom, id, mx, my);
    pair_t it;
    it.tx = 20'(tx); it.ty = 20'(ty); it.mom = 20'(mom);
    it.id = 8'(id); it.mx = 20'(mx); it.my = 20'(my);
    return it;
  endfunction

  initial begin
    pair_t dir[$];
    logic [7:0] scales[5] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd64};
    board.scale = 8'(SF_RESET);
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, unknown momentum, hole, edge lines, beyond sides, corners, tiles
    dir = {dir, mk(0, 0, 0, 0, 0, 0)};
    dir = {dir, mk(-524288, -524288, -524288, 255, 524287, 524287)};
    dir = {dir, mk(524287, 524287, 524287, 143, -524288, -524288)};
    dir = {dir, mk(100, 50, -5, 144, 0, 0)};
    dir = {dir, mk(EDGE, 100, 1, 10, EDGE, 100)};
    dir = {dir, mk(EDGE + 50, 3000, 5000, 20, 0, 0)};
    dir = {dir, mk(-3000, -EDGE - 80, 10000, 150, 0, 0)};
    dir = {dir, mk(EDGE + 9, -EDGE - 7, 700, 1, 0, 0)};
    dir = {dir, mk(HOLE, 0, 300, 2, 0, 0)};
    dir = {dir, mk(HOLE + 1, 0, 300, 2, 0, 0)};
    dir = {dir, mk(5000, 5000, 2000, 5, 5000 - HALF_BIG, 4000)};
    dir = {dir, mk(5000, 5000, 2000, 144, 5000 + HALF_SMALL, 5000 + HALF_SMALL)};
    dir = {dir, mk(5000, 5000, 2000, 5, 5000 - HALF_BIG - 30, 5000 + HALF_BIG + 40)};
    dir = {dir, mk(5000, 5000, 2000, 5, 5000 + HALF_BIG + 30, 5000 - HALF_BIG - 40)};
    dir = {dir, mk(5000, 5000, 2000, 200, 4990, 5000 + HALF_SMALL + 9)};
    dir = {dir, mk(5000, 5000, 2000, 200, 5000 - 100, 5010)};
    dir = {dir, mk(-20000, 7000, 1, 0, -20100, 7000)};
    foreach (dir[i]) send_pair(dir[i], 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_scale(scales[ph]);
      for (int n = 0; n < 360; n++) send_pair(rand_pair(), ph == 2 && n < 150);
      // hold the sender until every result is back
      drain();
      if (ph == 3) rx_quiet = 1;
    end

    $display("covered %0d pairs over five scale settings incl. 0 and 255, with",
             sent);
    $display("random gaps and stalls, back-to-back bursts and a stall-free phase");
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("testbench failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ttgm_pkg.sv
rtl/ttgm_div.sv
rtl/ttgm_isqrt.sv
rtl/track_tile_geometric_match_unit.sv
sim/testbench.sv
